// ----- hdl/pse_pkg.sv -----
package pse_pkg;

  localparam int SYMBOL_W = 8;
  localparam int VALUE_W  = 8;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [SYMBOL_W-1:0] SYM_END = 8'h24;  // '$'
  localparam logic [SYMBOL_W-1:0] SYM_A   = 8'h61;  // 'a'
  localparam logic [SYMBOL_W-1:0] SYM_B   = 8'h62;  // 'b'
  localparam logic [SYMBOL_W-1:0] SYM_C   = 8'h63;  // 'c'
  localparam logic [SYMBOL_W-1:0] SYM_ADD = 8'h2b;  // '+'
  localparam logic [SYMBOL_W-1:0] SYM_MUL = 8'h2a;  // '*'
  localparam logic [SYMBOL_W-1:0] SYM_SUB = 8'h2d;  // '-'
  localparam logic [SYMBOL_W-1:0] SYM_DIV = 8'h2f;  // '/'

  localparam logic [CFG_IDX_W-1:0] CFG_OPERAND_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPERAND_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OPERAND_C = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_EXTRA = 3'd1,
    ST_UNDER = 3'd2,
    ST_OVER  = 3'd3,
    ST_DIVZ  = 3'd4
  } pse_status_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } pse_op_t;

  // stack command: at most one write and one read per cycle
  typedef struct packed {
    logic push;       // write at depth, depth + 1
    logic replace2;   // write at depth - 2, depth - 1
    logic clear;      // depth to zero
    logic rd_top;     // read depth - 1
    logic rd_second;  // read depth - 2
  } pse_stk_cmd_t;

  typedef struct packed {
    logic is_empty;
    logic below_two;
    logic is_full;
    logic more_than_one;
  } pse_stk_stat_t;

  typedef struct packed {
    logic    start;
    pse_op_t op;
  } pse_alu_ctl_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } pse_alu_stat_t;

endpackage

// ----- hdl/pse_if.sv -----
interface pse_in_if import pse_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SYMBOL_W-1:0] symbol;

  modport source (output valid, output symbol, input ready);
  modport sink   (input valid, input symbol, output ready);
endinterface

interface pse_out_if import pse_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  value;
  logic        [STATUS_W-1:0] status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

// ----- hdl/pse_stack.sv -----
module pse_stack import pse_pkg::*; #(
  parameter int STACK_DEPTH = 32,
  parameter int DATA_WIDTH  = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pse_stk_cmd_t          cmd,
  input  logic [DATA_WIDTH-1:0] wr_data,
  output logic [DATA_WIDTH-1:0] rd_data,
  output pse_stk_stat_t         stat
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic [DW-1:0]         depth_r;
  logic [DW-1:0]         depth_m1;
  logic [DW-1:0]         depth_m2;

  assign depth_m1 = depth_r - DW'(1);
  assign depth_m2 = depth_r - DW'(2);

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[depth_r[AW-1:0]] <= wr_data;
    end else if (cmd.replace2) begin
      mem[depth_m2[AW-1:0]] <= wr_data;
    end
    if (cmd.rd_top) begin
      rd_data_r <= mem[depth_m1[AW-1:0]];
    end else if (cmd.rd_second) begin
      rd_data_r <= mem[depth_m2[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else if (cmd.clear) begin
      depth_r <= '0;
    end else if (cmd.push) begin
      depth_r <= depth_r + DW'(1);
    end else if (cmd.replace2) begin
      depth_r <= depth_m1;
    end
  end

  assign rd_data             = rd_data_r;
  assign stat.is_empty       = (depth_r == '0);
  assign stat.below_two      = (depth_r < DW'(2));
  assign stat.is_full        = (depth_r == DW'(STACK_DEPTH));
  assign stat.more_than_one  = (depth_r > DW'(1));

endmodule

// ----- hdl/pse_alu.sv -----
module pse_alu import pse_pkg::*; #(
  parameter int DATA_WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pse_alu_ctl_t          ctl,
  input  logic [DATA_WIDTH-1:0] x,     // first popped
  input  logic [DATA_WIDTH-1:0] y,     // second popped
  output logic [DATA_WIDTH-1:0] result,
  output pse_alu_stat_t         stat
);

  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(DATA_WIDTH);

  typedef enum logic [1:0] {A_IDLE, A_DIV, A_FIX} alu_state_t;

  alu_state_t    state_r;
  logic [W-1:0]  res_r;
  logic          done_r;
  logic          divz_r;
  logic [W:0]    rem_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  den_r;
  logic          neg_r;
  logic [CW-1:0] cnt_r;

  logic [W-1:0]  x_mag;
  logic [W-1:0]  y_mag;
  logic [W:0]    rem_shift;
  logic [W:0]    trial;
  logic [W:0]    rem_nxt;
  logic [W-1:0]  quo_nxt;

  assign x_mag = x[W-1] ? (~x + W'(1)) : x;
  assign y_mag = y[W-1] ? (~y + W'(1)) : y;

  // one restoring step: shift in the next dividend bit, try the subtract
  always_comb begin
    rem_shift = {rem_r[W-1:0], quo_r[W-1]};
    trial     = rem_shift - {1'b0, den_r};
    if (!trial[W]) begin
      rem_nxt = trial;
      quo_nxt = {quo_r[W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_shift;
      quo_nxt = {quo_r[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
      divz_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        A_IDLE: begin
          if (ctl.start) begin
            divz_r <= 1'b0;
            case (ctl.op)
              OP_ADD: begin
                res_r  <= y + x;
                done_r <= 1'b1;
              end
              OP_SUB: begin
                res_r  <= y - x;
                done_r <= 1'b1;
              end
              OP_MUL: begin
                res_r  <= y * x;
                done_r <= 1'b1;
              end
              default: begin
                if (x == '0) begin
                  res_r  <= '0;
                  divz_r <= 1'b1;
                  done_r <= 1'b1;
                end else begin
                  rem_r   <= '0;
                  quo_r   <= y_mag;
                  den_r   <= x_mag;
                  neg_r   <= x[W-1] ^ y[W-1];
                  cnt_r   <= CW'(W - 1);
                  state_r <= A_DIV;
                end
              end
            endcase
          end
        end
        A_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          if (cnt_r == '0) begin
            state_r <= A_FIX;
          end else begin
            cnt_r <= cnt_r - CW'(1);
          end
        end
        A_FIX: begin
          res_r   <= neg_r ? (~quo_r + W'(1)) : quo_r;
          done_r  <= 1'b1;
          state_r <= A_IDLE;
        end
        default: begin
          state_r <= A_IDLE;
        end
      endcase
    end
  end

  assign result        = res_r;
  assign stat.done     = done_r;
  assign stat.div_zero = divz_r;

endmodule

// ----- hdl/postfix_stack_evaluator.sv -----
// Postfix expression evaluator.
// in_ch carries one ASCII character per beat. 'a', 'b' and 'c' push the
// operand registers (sign-extended to DATA_WIDTH); '+', '-', '*' and '/'
// pop two entries and push second-popped op first-popped, wrapped, with
// division truncating toward zero; '$' pops the final value and sends one
// beat on out_ch with value and status, then empties the stack and clears
// the sticky error. Every other character is dropped without a result.
// cfg_we/cfg_index/cfg_wdata write operand_a, operand_b and operand_c
// (index 0, 1, 2); write them only while the block is idle.
// One character is in work at a time: S_DECODE follows each accept; an
// operator then passes S_RD_X, S_RD_Y and S_WAIT (the shared ALU runs a
// restoring divider one quotient bit a cycle for '/'), and '$' on a
// non-empty stack passes S_END_RD (one registered stack memory read).
// The '$' result lands in an output register; later characters are taken
// while it waits. A '$' is held only while that register is still full
// and out_ch.ready is low.
// Reset (rst_n low at a clock edge) empties the stack, clears the error,
// zeroes the operand registers and drops any pending result.
module postfix_stack_evaluator import pse_pkg::*; #(
  parameter int STACK_DEPTH = 32,
  parameter int DATA_WIDTH  = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  pse_in_if.sink               in_ch,
  pse_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD_X,
    S_RD_Y,
    S_WAIT,
    S_END_RD
  } state_t;

  state_t                state_r, state_nxt;
  logic [SYMBOL_W-1:0]   sym_r, sym_nxt;
  logic [DATA_WIDTH-1:0] x_r, x_nxt;
  pse_status_t           err_r, err_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]    out_value_r, out_value_nxt;
  pse_status_t           out_status_r, out_status_nxt;

  logic [CFG_W-1:0]      operand_a_r;
  logic [CFG_W-1:0]      operand_b_r;
  logic [CFG_W-1:0]      operand_c_r;

  pse_stk_cmd_t          stk_cmd;
  pse_stk_stat_t         stk_stat;
  logic [DATA_WIDTH-1:0] stk_wdata;
  logic [DATA_WIDTH-1:0] stk_rdata;

  pse_alu_ctl_t          alu_ctl;
  pse_alu_stat_t         alu_stat;
  logic [DATA_WIDTH-1:0] alu_result;

  pse_op_t               op_sel;
  logic                  out_busy;

  pse_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (stk_cmd),
    .wr_data (stk_wdata),
    .rd_data (stk_rdata),
    .stat    (stk_stat)
  );

  pse_alu #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (alu_ctl),
    .x      (x_r),
    .y      (stk_rdata),
    .result (alu_result),
    .stat   (alu_stat)
  );

  // operand registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      operand_a_r <= '0;
      operand_b_r <= '0;
      operand_c_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OPERAND_A: operand_a_r <= cfg_wdata;
        CFG_OPERAND_B: operand_b_r <= cfg_wdata;
        CFG_OPERAND_C: operand_c_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sym_r)
      SYM_ADD: op_sel = OP_ADD;
      SYM_SUB: op_sel = OP_SUB;
      SYM_MUL: op_sel = OP_MUL;
      default: op_sel = OP_DIV;
    endcase
  end

  // the result register is full and not taken this cycle
  assign out_busy = out_valid_r && !out_ch.ready;

  always_comb begin
    state_nxt      = state_r;
    sym_nxt        = sym_r;
    x_nxt          = x_r;
    err_nxt        = err_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    stk_cmd        = '0;
    stk_wdata      = alu_result;
    alu_ctl.start  = 1'b0;
    alu_ctl.op     = op_sel;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          sym_nxt   = in_ch.symbol;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        state_nxt = S_IDLE;
        case (sym_r)
          SYM_A, SYM_B, SYM_C: begin
            // drop the push on a full stack and keep the first error only
            case (sym_r)
              SYM_A:   stk_wdata = DATA_WIDTH'($signed(operand_a_r));
              SYM_B:   stk_wdata = DATA_WIDTH'($signed(operand_b_r));
              default: stk_wdata = DATA_WIDTH'($signed(operand_c_r));
            endcase
            if (stk_stat.is_full) begin
              if (err_r == ST_OK) begin
                err_nxt = ST_OVER;
              end
            end else begin
              stk_cmd.push = 1'b1;
            end
          end
          SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV: begin
            if (stk_stat.below_two) begin
              if (err_r == ST_OK) begin
                err_nxt = ST_UNDER;
              end
            end else begin
              stk_cmd.rd_top = 1'b1;
              state_nxt      = S_RD_X;
            end
          end
          SYM_END: begin
            if (out_busy) begin
              // hold the end marker until the previous result is taken
              state_nxt = S_DECODE;
            end else if (stk_stat.is_empty) begin
              out_valid_nxt  = 1'b1;
              out_value_nxt  = '0;
              out_status_nxt = (err_r != ST_OK) ? err_r : ST_UNDER;
              err_nxt        = ST_OK;
              stk_cmd.clear  = 1'b1;
            end else begin
              stk_cmd.rd_top = 1'b1;
              state_nxt      = S_END_RD;
            end
          end
          default: ;
        endcase
      end

      S_RD_X: begin
        x_nxt             = stk_rdata;
        stk_cmd.rd_second = 1'b1;
        state_nxt         = S_RD_Y;
      end

      S_RD_Y: begin
        // second-popped entry is on the read port now; start the ALU
        alu_ctl.start = 1'b1;
        state_nxt     = S_WAIT;
      end

      S_WAIT: begin
        if (alu_stat.done) begin
          stk_cmd.replace2 = 1'b1;
          if (alu_stat.div_zero && (err_r == ST_OK)) begin
            err_nxt = ST_DIVZ;
          end
          state_nxt = S_IDLE;
        end
      end

      S_END_RD: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = stk_rdata[VALUE_W-1:0];
        if (err_r != ST_OK) begin
          out_status_nxt = err_r;
        end else if (stk_stat.more_than_one) begin
          out_status_nxt = ST_EXTRA;
        end else begin
          out_status_nxt = ST_OK;
        end
        err_nxt       = ST_OK;
        stk_cmd.clear = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sym_r        <= sym_nxt;
    x_r          <= x_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = out_value_r;
  assign out_ch.status = out_status_r;

endmodule
